FILE: rtl/core/lpht_pkg.sv
`timescale 1ns / 1ps

package lpht_pkg;

   // Fixed field widths on the ports
   localparam int HASH_W  = 32;
   localparam int KEY_W   = 32;
   localparam int VALUE_W = 32;
   localparam int CAP_W   = 9;

   // Default build parameters
   localparam int SLOTS_DEFAULT      = 256;
   localparam int KEY_BITS_DEFAULT   = 32;
   localparam int VALUE_BITS_DEFAULT = 32;

   localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;
   // Largest capacity the register can express; no probe goes past it
   localparam int CAP_MAX = (1 << CAP_W) - 1;

   // Remainder unit: quotient bits retired per cycle
   localparam int DIV_STEP   = 4;
   localparam int DIV_CYCLES = HASH_W / DIV_STEP;
   localparam int DIV_CNT_W  = $clog2(DIV_CYCLES);

   localparam logic FUNC_INSERT = 1'b0;
   localparam logic FUNC_LOOKUP = 1'b1;

   typedef enum logic [1:0] {
      STATUS_INSERTED = 2'd0,
      STATUS_FULL     = 2'd1,
      STATUS_FOUND    = 2'd2,
      STATUS_MISSING  = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_PROBE,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic rd_en;
      logic wr_en;
   } store_ctl_type;

   typedef struct packed {
      logic clear_busy;
      logic rd_used;
   } store_sts_type;

endpackage

FILE: rtl/core/lpht_divider.sv
`timescale 1ns / 1ps

// Iterative remainder: dividend % divisor, DIV_STEP bits per cycle.
module lpht_divider (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [lpht_pkg::HASH_W-1:0] dividend,
   input  logic [lpht_pkg::CAP_W-1:0]  divisor,
   output logic                        done,
   output logic [lpht_pkg::CAP_W-1:0]  remainder
);
   import lpht_pkg::*;

   logic                 run_ff, run_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [HASH_W-1:0]    dvd_ff, dvd_in;
   logic [CAP_W-1:0]     dsr_ff, dsr_in;
   logic [CAP_W-1:0]     rem_ff, rem_in;

   always_comb begin
      logic [CAP_W:0] r;
      r       = {1'b0, rem_ff};
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      dsr_in  = dsr_ff;
      rem_in  = rem_ff;
      if (start) begin
         run_in = 1'b1;
         cnt_in = '0;
         dvd_in = dividend;
         dsr_in = divisor;
         rem_in = '0;
      end else if (run_ff) begin
         // remainder stays below divisor, so shifted value fits CAP_W+1 bits
         for (int i = 0; i < DIV_STEP; i++) begin
            r = {r[CAP_W-1:0], dvd_ff[HASH_W-1-i]};
            if (r >= {1'b0, dsr_ff}) begin
               r = r - {1'b0, dsr_ff};
            end
         end
         rem_in = r[CAP_W-1:0];
         dvd_in = dvd_ff << DIV_STEP;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(DIV_CYCLES - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
      rem_ff <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

FILE: rtl/core/lpht_store.sv
`timescale 1ns / 1ps

// Slot storage: a used-bit memory swept clear after reset, and a key/value
// memory with no reset. Both have registered read outputs.
module lpht_store #(
   parameter int DEPTH      = 256,
   parameter int ADDR_W     = 8,
   parameter int KEY_BITS   = 32,
   parameter int VALUE_BITS = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  lpht_pkg::store_ctl_type ctl,
   input  logic [ADDR_W-1:0]       rd_addr,
   input  logic [ADDR_W-1:0]       wr_addr,
   input  logic [KEY_BITS-1:0]     wr_key,
   input  logic [VALUE_BITS-1:0]   wr_value,
   output lpht_pkg::store_sts_type sts,
   output logic [KEY_BITS-1:0]     rd_key,
   output logic [VALUE_BITS-1:0]   rd_value
);
   import lpht_pkg::*;

   logic                  used_mem [DEPTH];
   logic [KEY_BITS-1:0]   key_mem  [DEPTH];
   logic [VALUE_BITS-1:0] val_mem  [DEPTH];

   logic                  clr_busy_ff, clr_busy_in;
   logic [ADDR_W-1:0]     clr_addr_ff, clr_addr_in;
   logic                  rd_used_ff;
   logic [KEY_BITS-1:0]   rd_key_ff;
   logic [VALUE_BITS-1:0] rd_value_ff;

   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_addr_in = clr_addr_ff;
      if (clr_busy_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == ADDR_W'(DEPTH - 1)) begin
            clr_busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clr_busy_ff <= clr_busy_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         used_mem[clr_addr_ff] <= 1'b0;
      end else if (ctl.wr_en) begin
         used_mem[wr_addr] <= 1'b1;
      end
      if (ctl.rd_en) begin
         rd_used_ff <= used_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         key_mem[wr_addr] <= wr_key;
         val_mem[wr_addr] <= wr_value;
      end
      if (ctl.rd_en) begin
         rd_key_ff   <= key_mem[rd_addr];
         rd_value_ff <= val_mem[rd_addr];
      end
   end

   assign sts.clear_busy = clr_busy_ff;
   assign sts.rd_used    = rd_used_ff;
   assign rd_key         = rd_key_ff;
   assign rd_value       = rd_value_ff;

endmodule

FILE: rtl/core/linear_probe_hash_table_unit.sv
`timescale 1ns / 1ps

// Channel  Direction  Handshake             Payload
// req      in         req_valid/req_stall   req_func, req_key, req_hash, req_value
// rsp      out        rsp_valid/rsp_stall   rsp_status, rsp_result_value
// csr      in         csr_write_enable      csr_write_data (capacity)
//
// One transaction at a time: hash % capacity is computed in the remainder unit,
// then one probe per cycle through the slot memory read port, then ST_FINISH
// loads the output register; the next request can be taken in the same cycle
// that the response is valid.
// After reset the used-bit memory is swept clear over min(SLOTS, 511) slots,
// with req_stall high. A stalled response sits in the output register while
// the next request is taken; a finished transaction waits for that register.
module linear_probe_hash_table_unit #(
   parameter int SLOTS      = lpht_pkg::SLOTS_DEFAULT,
   parameter int KEY_BITS   = lpht_pkg::KEY_BITS_DEFAULT,
   parameter int VALUE_BITS = lpht_pkg::VALUE_BITS_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_func,
   input  logic [lpht_pkg::KEY_W-1:0]   req_key,
   input  logic [lpht_pkg::HASH_W-1:0]  req_hash,
   input  logic [lpht_pkg::VALUE_W-1:0] req_value,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [1:0]                   rsp_status,
   output logic [lpht_pkg::VALUE_W-1:0] rsp_result_value,
   input  logic                         csr_write_enable,
   input  logic [lpht_pkg::CAP_W-1:0]   csr_write_data
);
   import lpht_pkg::*;

   // slots at or above the largest capacity are never probed
   localparam int DEPTH  = (SLOTS < CAP_MAX) ? SLOTS : CAP_MAX;
   localparam int ADDR_W = $clog2(DEPTH);

   state_type state_ff, state_in;

   logic [CAP_W-1:0]      cap_ff, cap_in;
   logic [CAP_W-1:0]      eff_cap;
   logic                  accept;

   logic                  item_func_ff, item_func_in;
   logic [KEY_BITS-1:0]   item_key_ff, item_key_in;
   logic [VALUE_BITS-1:0] item_value_ff, item_value_in;

   logic [ADDR_W-1:0]     iss_pos_ff, iss_pos_in;
   logic [ADDR_W-1:0]     chk_pos_ff, chk_pos_in;
   logic [CAP_W-1:0]      chk_cnt_ff, chk_cnt_in;
   logic                  rd_pend_ff, rd_pend_in;

   status_type            res_status_ff, res_status_in;
   logic [VALUE_W-1:0]    res_value_ff, res_value_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   status_type            rsp_status_ff, rsp_status_in;
   logic [VALUE_W-1:0]    rsp_value_ff, rsp_value_in;

   logic                  div_start, div_done;
   logic [CAP_W-1:0]      div_rem;

   store_ctl_type         st_ctl;
   store_sts_type         st_sts;
   logic [KEY_BITS-1:0]   st_rd_key;
   logic [VALUE_BITS-1:0] st_rd_value;

   logic                  probe_done, probe_write, out_free;
   status_type            probe_status;
   logic [VALUE_W-1:0]    probe_value;
   logic [CAP_W-1:0]      iss_next;

   lpht_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (req_hash),
      .divisor   (eff_cap),
      .done      (div_done),
      .remainder (div_rem)
   );

   lpht_store #(
      .DEPTH      (DEPTH),
      .ADDR_W     (ADDR_W),
      .KEY_BITS   (KEY_BITS),
      .VALUE_BITS (VALUE_BITS)
   ) u_store (
      .clock    (clock),
      .reset    (reset),
      .ctl      (st_ctl),
      .rd_addr  (iss_pos_ff),
      .wr_addr  (chk_pos_ff),
      .wr_key   (item_key_ff),
      .wr_value (item_value_ff),
      .sts      (st_sts),
      .rd_key   (st_rd_key),
      .rd_value (st_rd_value)
   );

   // capacity of 0 acts as 1, above the slot count saturates
   always_comb begin
      if (cap_ff == '0) begin
         eff_cap = CAP_W'(1);
      end else if (cap_ff > CAP_W'(DEPTH)) begin
         eff_cap = CAP_W'(DEPTH);
      end else begin
         eff_cap = cap_ff;
      end
   end

   assign accept   = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // evaluate the slot whose read data arrived this cycle
   always_comb begin
      probe_done   = 1'b0;
      probe_write  = 1'b0;
      probe_status = (item_func_ff == FUNC_LOOKUP) ? STATUS_MISSING : STATUS_FULL;
      probe_value  = '0;
      if (state_ff == ST_PROBE && rd_pend_ff) begin
         if (item_func_ff == FUNC_LOOKUP) begin
            if (!st_sts.rd_used) begin
               probe_done = 1'b1;
            end else if (st_rd_key == item_key_ff) begin
               probe_done   = 1'b1;
               probe_status = STATUS_FOUND;
               probe_value  = VALUE_W'(st_rd_value);
            end
         end else if (!st_sts.rd_used) begin
            probe_done   = 1'b1;
            probe_write  = 1'b1;
            probe_status = STATUS_INSERTED;
         end
         if (chk_cnt_ff + 1'b1 == eff_cap) begin
            probe_done = 1'b1;
         end
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (accept)     state_in = ST_DIVIDE;
         ST_DIVIDE: if (div_done)   state_in = ST_PROBE;
         ST_PROBE:  if (probe_done) state_in = ST_FINISH;
         ST_FINISH: if (out_free)   state_in = ST_IDLE;
         default:                   state_in = ST_IDLE;
      endcase
   end

   // state machine outputs
   always_comb begin
      req_stall    = 1'b1;
      div_start    = 1'b0;
      st_ctl.rd_en = 1'b0;
      st_ctl.wr_en = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = st_sts.clear_busy;
            div_start = accept;
         end
         ST_PROBE: begin
            st_ctl.rd_en = 1'b1;
            st_ctl.wr_en = probe_write;
         end
         ST_DIVIDE, ST_FINISH: begin
         end
         default: begin
         end
      endcase
   end

   // datapath
   always_comb begin
      cap_in        = csr_write_enable ? csr_write_data : cap_ff;
      item_func_in  = item_func_ff;
      item_key_in   = item_key_ff;
      item_value_in = item_value_ff;
      iss_pos_in    = iss_pos_ff;
      chk_pos_in    = chk_pos_ff;
      chk_cnt_in    = chk_cnt_ff;
      rd_pend_in    = 1'b0;
      res_status_in = res_status_ff;
      res_value_in  = res_value_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;

      iss_next = CAP_W'(iss_pos_ff) + 1'b1;
      if (iss_next == eff_cap) begin
         iss_next = '0;
      end

      if (accept) begin
         item_func_in  = req_func;
         item_key_in   = KEY_BITS'(req_key);
         item_value_in = VALUE_BITS'(req_value);
      end

      if (state_ff == ST_DIVIDE && div_done) begin
         // remainder is below the capacity, so it fits the slot index
         iss_pos_in = div_rem[ADDR_W-1:0];
         chk_cnt_in = '0;
      end

      if (state_ff == ST_PROBE) begin
         // reads run one slot ahead of the check
         iss_pos_in = iss_next[ADDR_W-1:0];
         chk_pos_in = iss_pos_ff;
         rd_pend_in = !probe_done;
         if (rd_pend_ff) begin
            chk_cnt_in = chk_cnt_ff + 1'b1;
         end
         if (probe_done) begin
            res_status_in = probe_status;
            res_value_in  = probe_value;
         end
      end

      if (state_ff == ST_FINISH && out_free) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = res_status_ff;
         rsp_value_in  = res_value_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cap_ff       <= CAP_RESET;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cap_ff       <= cap_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      item_func_ff  <= item_func_in;
      item_key_ff   <= item_key_in;
      item_value_ff <= item_value_in;
      iss_pos_ff    <= iss_pos_in;
      chk_pos_ff    <= chk_pos_in;
      chk_cnt_ff    <= chk_cnt_in;
      res_status_ff <= res_status_in;
      res_value_ff  <= res_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_result_value = rsp_value_ff;

endmodule

FILE: dv/linear_probe_hash_table_unit_test.sv
`timescale 1ns / 1ps

module linear_probe_hash_table_unit_test;
   import lpht_pkg::*;

   localparam int QUIET_LIMIT = 4000;
   localparam int PHASES = 10;
   localparam int PHASE_ITEMS = 70;
   localparam int POOL_DEPTH = 64;

   typedef struct {
      status_type       status;
      logic [VALUE_W-1:0] value;
   } probe_outcome_type;

   typedef struct {
      logic [KEY_W-1:0]  key;
      logic [HASH_W-1:0] hash;
   } key_hash_type;

   logic                clock;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic                req_func = FUNC_INSERT;
   logic [KEY_W-1:0]    req_key = '0;
   logic [HASH_W-1:0]   req_hash = '0;
   logic [VALUE_W-1:0]  req_value = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [1:0]          rsp_status;
   logic [VALUE_W-1:0]  rsp_result_value;
   logic                csr_write_enable = 1'b0;
   logic [CAP_W-1:0]    csr_write_data = '0;

   // shadow copy of the table and its capacity register
   logic                shadow_used [SLOTS_DEFAULT];
   logic [KEY_W-1:0]    shadow_key [SLOTS_DEFAULT];
   logic [VALUE_W-1:0]  shadow_value [SLOTS_DEFAULT];
   logic [CAP_W-1:0]    shadow_cap = CAP_RESET;

   probe_outcome_type   probe_outcomes[$];
   key_hash_type        key_pool[$];

   int mismatch_count = 0;
   int insert_count = 0;
   int lookup_count = 0;
   int cap_writes = 0;
   int status_seen [4] = '{0, 0, 0, 0};
   int quiet_cycles = 0;
   int hold_request = 0;
   int hold_count = 0;
   bit req_gaps_on = 1'b1;
   bit rsp_gaps_on = 1'b1;

   linear_probe_hash_table_unit u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_func         (req_func),
      .req_key          (req_key),
      .req_hash         (req_hash),
      .req_value        (req_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_result_value (rsp_result_value),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // Mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Insert or lookup against the shadow table; updates it on a successful insert
   function automatic probe_outcome_type run_shadow_probe(input logic func,
         input logic [KEY_W-1:0] key, input logic [HASH_W-1:0] hash,
         input logic [VALUE_W-1:0] data);
      probe_outcome_type res;
      int unsigned span;
      int unsigned pos;
      int unsigned n;
      bit done;
      if (shadow_cap == 0)
         span = 1;
      else if (shadow_cap > SLOTS_DEFAULT)
         span = SLOTS_DEFAULT;
      else
         span = shadow_cap;
      pos = hash % span;
      res.status = (func == FUNC_LOOKUP) ? STATUS_MISSING : STATUS_FULL;
      res.value = '0;
      done = 1'b0;
      for (n = 0; n < span && !done; n++) begin
         if (func == FUNC_LOOKUP) begin
            if (!shadow_used[pos]) begin
               done = 1'b1;
            end else if (shadow_key[pos] == key) begin
               res.status = STATUS_FOUND;
               res.value = shadow_value[pos];
               done = 1'b1;
            end
         end else if (!shadow_used[pos]) begin
            shadow_used[pos] = 1'b1;
            shadow_key[pos] = key;
            shadow_value[pos] = data;
            res.status = STATUS_INSERTED;
            done = 1'b1;
         end
         pos = (pos + 1 == span) ? 0 : pos + 1;
      end
      return res;
   endfunction

   task automatic log_mismatch(input string msg);
      mismatch_count++;
      $display("[%0t] MISMATCH: %s", $realtime, msg);
   endtask

   task automatic send_request(input logic func, input logic [KEY_W-1:0] key,
         input logic [HASH_W-1:0] hash, input logic [VALUE_W-1:0] data);
      int gap;
      req_valid <= 1'b1;
      req_func <= func;
      req_key <= key;
      req_hash <= hash;
      req_value <= data;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      probe_outcomes.push_back(run_shadow_probe(func, key, hash, data));
      if (func == FUNC_INSERT)
         insert_count++;
      else
         lookup_count++;
      gap = req_gaps_on ? pick_gap() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_quiet();
      req_valid <= 1'b0;
      while (probe_outcomes.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_capacity(input logic [CAP_W-1:0] cap);
      wait_quiet();
      csr_write_enable <= 1'b1;
      csr_write_data <= cap;
      @(posedge clock);
      shadow_cap = cap;
      cap_writes++;
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   // Response checker: in-order compare against the shadow table's outcomes
   always @(posedge clock) begin : check_rsp
      probe_outcome_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (probe_outcomes.size() == 0) begin
            log_mismatch($sformatf("response with nothing pending: status %0d value %h",
                                   rsp_status, rsp_result_value));
         end else begin
            want = probe_outcomes.pop_front();
            status_seen[rsp_status]++;
            if (rsp_status !== want.status)
               log_mismatch($sformatf("status %0d, wanted %s", rsp_status, want.status.name()));
            if (rsp_result_value !== want.value)
               log_mismatch($sformatf("result_value %h, wanted %h", rsp_result_value,
                                      want.value));
         end
      end
   end

   // Receiver pacing; each new hold request stalls the response side for as long as hold_request gives
   initial begin : rsp_pacing
      int stall_left;
      int gap;
      int holds_taken;
      stall_left = 0;
      holds_taken = 0;
      forever begin
         @(posedge clock);
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else if (hold_count != holds_taken) begin
            rsp_stall <= 1'b1;
            stall_left = hold_request - 1;
            holds_taken = hold_count;
         end else begin
            gap = (rsp_gaps_on && $urandom_range(0, 3) == 0) ? pick_gap() : 0;
            if (gap > 0) begin
               rsp_stall <= 1'b1;
               stall_left = gap - 1;
            end else begin
               rsp_stall <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
         $display("watchdog: no transaction for %0d cycles, %0d responses outstanding",
                  QUIET_LIMIT, probe_outcomes.size());
         $display("tb: failure");
         $finish;
      end
   end

   // Collisions, wraparound, duplicates and misses at the reset capacity
   task automatic test_directed_probing();
      send_request(FUNC_INSERT, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
      send_request(FUNC_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_request(FUNC_LOOKUP, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
      send_request(FUNC_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0001_2345);
      // home slot 255 is taken: probe wraps to slot 1
      send_request(FUNC_INSERT, 32'hA5A5_0001, 32'h0000_00FF, 32'h0000_1111);
      send_request(FUNC_LOOKUP, 32'hA5A5_0001, 32'h0000_00FF, 32'h0000_0000);
      // same key again lands further along; lookup must return the first copy
      send_request(FUNC_INSERT, 32'hA5A5_0001, 32'h0000_00FF, 32'h0000_2222);
      send_request(FUNC_LOOKUP, 32'hA5A5_0001, 32'h0000_00FF, 32'h0000_0000);
      send_request(FUNC_LOOKUP, 32'h0000_1234, 32'h0000_0010, 32'h0000_0000);
      send_request(FUNC_LOOKUP, 32'h0000_DEAD, 32'h0000_00FF, 32'h0000_0000);
   endtask

   // Out-of-range and shrunken capacities with entries left in place
   task automatic test_capacity_limits();
      write_capacity(9'd0);
      send_request(FUNC_INSERT, 32'h0000_0007, 32'h8000_0000, 32'h0000_0007);
      send_request(FUNC_LOOKUP, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000);
      send_request(FUNC_LOOKUP, 32'h0000_0007, 32'h0000_0003, 32'h0000_0000);
      write_capacity(9'd2);
      send_request(FUNC_INSERT, 32'h0000_0009, 32'h0000_0001, 32'h0000_0009);
      send_request(FUNC_LOOKUP, 32'hA5A5_0001, 32'h0000_0000, 32'h0000_0000);
      send_request(FUNC_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0000);
      write_capacity(9'd511);
      send_request(FUNC_LOOKUP, 32'hFFFF_FFFF, 32'h0000_01FF, 32'h0000_0000);
      send_request(FUNC_INSERT, 32'h8000_0000, 32'h7FFF_FFFF, 32'h5A5A_5A5A);
      send_request(FUNC_LOOKUP, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000);
      write_capacity(9'd3);
      send_request(FUNC_INSERT, 32'h0000_0042, 32'h0000_0005, 32'h0000_0042);
      send_request(FUNC_LOOKUP, 32'h8000_0000, 32'h0000_0000, 32'h0000_0000);
   endtask

   task automatic send_random_item(input int insert_pct);
      key_hash_type kh;
      int sel;
      sel = $urandom_range(0, 9);
      if ($urandom_range(0, 99) < insert_pct) begin
         if (key_pool.size() > 0 && sel == 0) begin
            kh = key_pool[$urandom_range(0, key_pool.size() - 1)];
         end else begin
            kh.key = $urandom;
            // narrow hashes pile up on the same home slots
            kh.hash = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom;
         end
         send_request(FUNC_INSERT, kh.key, kh.hash, $urandom);
         key_pool.push_back(kh);
         if (key_pool.size() > POOL_DEPTH)
            void'(key_pool.pop_front());
      end else begin
         if (key_pool.size() > 0 && sel < 6) begin
            kh = key_pool[$urandom_range(0, key_pool.size() - 1)];
         end else if (key_pool.size() > 0 && sel < 8) begin
            kh = key_pool[$urandom_range(0, key_pool.size() - 1)];
            kh.hash = $urandom;
         end else begin
            kh.key = $urandom;
            kh.hash = $urandom;
         end
         send_request(FUNC_LOOKUP, kh.key, kh.hash, $urandom);
      end
   endtask

   // Receiver holds off while requests keep coming, so the input has to stall
   task automatic test_input_backpressure();
      write_capacity(9'd256);
      req_gaps_on = 1'b0;
      hold_request = 300;
      hold_count++;
      repeat (12)
         send_random_item(50);
      req_gaps_on = 1'b1;
      wait_quiet();
   endtask

   task automatic test_random_traffic();
      logic [CAP_W-1:0] caps [PHASES] = '{9'd1, 9'd0, 9'd7, 9'd64, 9'd2, 9'd200, 9'd511,
                                          9'd300, 9'd256, 9'd256};
      int insert_pct [PHASES] = '{50, 50, 60, 50, 30, 50, 40, 40, 70, 95};
      for (int ph = 0; ph < PHASES; ph++) begin
         write_capacity(caps[ph]);
         req_gaps_on = (ph % 3 != 1);
         rsp_gaps_on = (ph % 4 != 2);
         repeat (PHASE_ITEMS)
            send_random_item(insert_pct[ph]);
      end
      req_gaps_on = 1'b1;
      rsp_gaps_on = 1'b1;
   endtask

   initial begin
      for (int i = 0; i < SLOTS_DEFAULT; i++) begin
         shadow_used[i] = 1'b0;
         shadow_key[i] = '0;
         shadow_value[i] = '0;
      end
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_probing();
      test_capacity_limits();
      test_input_backpressure();
      test_random_traffic();

      wait_quiet();
      repeat (40) @(posedge clock);
      $display("covered %0d requests (%0d inserts, %0d lookups) across %0d capacity writes",
               insert_count + lookup_count, insert_count, lookup_count, cap_writes);
      $display("responses: %0d inserted, %0d full, %0d found, %0d missing; %0d mismatches",
               status_seen[STATUS_INSERTED], status_seen[STATUS_FULL],
               status_seen[STATUS_FOUND], status_seen[STATUS_MISSING], mismatch_count);
      if (mismatch_count == 0 && probe_outcomes.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

FILE: files.f
rtl/core/lpht_pkg.sv
rtl/core/lpht_divider.sv
rtl/core/lpht_store.sv
rtl/core/linear_probe_hash_table_unit.sv
dv/linear_probe_hash_table_unit_test.sv
